>>> src/dma_command_queue_timer_assert.svh
// ----------------------------------------------------------------------------
// DMA command queue timer assertion macros
// Shared property macros for the checker of the DMA command queue timer.
// ----------------------------------------------------------------------------
// The macros expect signals named clk and arst_n in the scope of their use.
`ifndef DMA_COMMAND_QUEUE_TIMER_ASSERT_SVH
`define DMA_COMMAND_QUEUE_TIMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMAQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMAQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dmaq_pkg.sv
// ----------------------------------------------------------------------------
// DMA command queue timer package
// Payload types, configuration layout and codes shared by the queue modules.
// ----------------------------------------------------------------------------
package dmaq_pkg;

	// Item codes
	localparam logic CMD_ISSUE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LATENCY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STORE_LATENCY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 3'd4;
	localparam int CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic [7:0]  RST_CHANNEL_COUNT = 8'd1;
	localparam logic [15:0] RST_BLOCK_BYTES   = 16'd64;
	localparam logic [15:0] RST_LOAD_LATENCY  = 16'd0;
	localparam logic [15:0] RST_STORE_LATENCY = 16'd0;
	localparam logic [4:0]  RST_QUEUE_LIMIT   = 5'd16;

	// Request count divider
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = 5;
	localparam int DIVISOR_W = 24;

	typedef struct packed {
		logic        cmd;
		logic        is_store;
		logic [31:0] transfer_bytes;
		logic [7:0]  tag;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic        done_res;
		logic [7:0]  done_tag;
		logic [31:0] requests_issued;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  channel_count;
		logic [15:0] block_bytes;
		logic [15:0] load_latency_cycles;
		logic [15:0] store_latency_cycles;
		logic [4:0]  queue_limit;
	} cfg_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic        cmd;
		logic        is_store;
		logic [31:0] requests;
		logic [7:0]  tag;
	} op_t;

	// One queued command
	typedef struct packed {
		logic [7:0]  tag;
		logic [31:0] requests_left;
		logic [15:0] cycles_left;
	} entry_t;

endpackage

>>> src/dmaq_front.sv
// ----------------------------------------------------------------------------
// DMA command queue front end
// Accepts requests, works out the request count of an issue with a serial
// divider and hands classified items to the operation queue.
// ----------------------------------------------------------------------------
module dmaq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dmaq_pkg::in_item_t in_data,
	input  dmaq_pkg::cfg_t     cfg,
	output logic               op_valid,
	input  logic               op_ready,
	output dmaq_pkg::op_t      op_data
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t state_q;
	logic                           cmd_q;
	logic                           is_store_q;
	logic [7:0]                     tag_q;
	logic [31:0]                    quo_q;
	logic [dmaq_pkg::DIVISOR_W-1:0] rem_q;
	logic [dmaq_pkg::DIVISOR_W-1:0] den_q;
	logic [dmaq_pkg::STEP_W-1:0]    step_q;

	logic [dmaq_pkg::DIVISOR_W-1:0] prod;
	logic [dmaq_pkg::DIVISOR_W:0]   rem_sh;
	logic [dmaq_pkg::DIVISOR_W:0]   den_ext;
	logic [dmaq_pkg::DIVISOR_W:0]   rem_diff;
	logic                           ge;
	logic                           accept;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign op_valid = (state_q == F_PUSH);
	assign op_data  = '{cmd: cmd_q, is_store: is_store_q, requests: quo_q, tag: tag_q};

	// The two divisions collapse into one: floor(floor(a/b)/c) equals floor(a/(b*c)).
	// A zero channel count turns the first quotient into all ones, and a zero
	// divisor makes the restoring divider return all ones by itself.
	assign prod = {16'd0, cfg.channel_count} * {8'd0, cfg.block_bytes};

	assign rem_sh   = {rem_q, quo_q[31]};
	assign den_ext  = {1'b0, den_q};
	assign ge       = (rem_sh >= den_ext);
	assign rem_diff = rem_sh - den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= (in_data.cmd == dmaq_pkg::CMD_TICK) ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					if (step_q == dmaq_pkg::STEP_W'(dmaq_pkg::DIV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (op_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= in_data.cmd;
			is_store_q <= in_data.is_store;
			tag_q      <= in_data.tag;
			rem_q      <= '0;
			step_q     <= '0;
			if (cfg.channel_count == 8'd0) begin
				quo_q <= '1;
				den_q <= {8'd0, cfg.block_bytes};
			end else begin
				quo_q <= in_data.transfer_bytes;
				den_q <= prod;
			end
		end else if (state_q == F_DIV) begin
			quo_q  <= {quo_q[30:0], ge};
			rem_q  <= ge ? rem_diff[dmaq_pkg::DIVISOR_W-1:0]
			             : rem_sh[dmaq_pkg::DIVISOR_W-1:0];
			step_q <= step_q + 1'b1;
		end
	end

endmodule

>>> src/dmaq_op_fifo.sv
// ----------------------------------------------------------------------------
// DMA command queue operation FIFO
// Two-entry queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module dmaq_op_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  dmaq_pkg::op_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output dmaq_pkg::op_t pop_data
);

	localparam logic [1:0] FULL_COUNT = 2'd2;

	dmaq_pkg::op_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != FULL_COUNT);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> src/dmaq_back.sv
// ----------------------------------------------------------------------------
// DMA command queue back end
// Holds the command queue in a memory, carries out issues and ticks in order
// and drives the result register.
// ----------------------------------------------------------------------------
module dmaq_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_ready,
	input  dmaq_pkg::op_t       op_data,
	input  dmaq_pkg::cfg_t      cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output dmaq_pkg::out_item_t out_data
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > 5) ? CW : 5;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_EXEC = 2'b10
	} back_state_t;

	back_state_t state_q;
	dmaq_pkg::entry_t mem_q [QUEUE_DEPTH];
	dmaq_pkg::entry_t rd_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [31:0]   issued_q;
	logic          out_valid_q;
	dmaq_pkg::out_item_t out_data_q;

	logic          slot_free;
	logic          pop;
	logic          is_issue;
	logic          room;
	logic [LW-1:0] limit_ext;
	logic [LW-1:0] depth_ext;
	logic [LW-1:0] eff_limit;
	logic          enqueue;
	logic          exec_go;
	logic          out_load;
	logic          req_nz;
	logic [31:0]   req_next;
	logic [15:0]   cyc_next;
	logic          retire;
	logic [31:0]   issued_next;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	dmaq_pkg::entry_t wr_entry;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign slot_free = !out_valid_q || out_ready;

	assign op_ready = (state_q == B_IDLE) && slot_free;
	assign pop      = op_valid && op_ready;
	assign is_issue = (op_data.cmd == dmaq_pkg::CMD_ISSUE);

	// The queue limit never exceeds the storage depth.
	assign limit_ext = LW'(cfg.queue_limit);
	assign depth_ext = LW'(QUEUE_DEPTH);
	assign eff_limit = (limit_ext < depth_ext) ? limit_ext : depth_ext;
	assign room      = (LW'(count_q) < eff_limit);
	assign enqueue   = pop && is_issue && room;

	// Head update: one request first, then the latency countdown.
	assign exec_go     = (state_q == B_EXEC) && slot_free;
	assign out_load    = (pop && (is_issue || (count_q == '0))) || exec_go;
	assign req_nz      = (rd_q.requests_left != 32'd0);
	assign req_next    = req_nz ? rd_q.requests_left - 32'd1 : rd_q.requests_left;
	assign issued_next = req_nz ? issued_q + 32'd1 : issued_q;

	always_comb begin
		cyc_next = rd_q.cycles_left;
		retire   = 1'b0;
		if (req_next == 32'd0) begin
			if (rd_q.cycles_left != 16'd0) begin
				cyc_next = rd_q.cycles_left - 16'd1;
			end
			retire = (cyc_next == 16'd0);
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		wr_entry = '{tag: op_data.tag, requests_left: op_data.requests,
			cycles_left: op_data.is_store ? cfg.store_latency_cycles
			                              : cfg.load_latency_cycles};
		if (exec_go) begin
			wr_en    = 1'b1;
			wr_addr  = head_q;
			wr_entry = '{tag: rd_q.tag, requests_left: req_next, cycles_left: cyc_next};
		end else if (enqueue) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		rd_q <= mem_q[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			issued_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (is_issue) begin
							if (room) begin
								tail_q  <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0
								                                            : tail_q + 1'b1;
								count_q <= count_q + 1'b1;
							end
						end else if (count_q != '0) begin
							state_q <= B_EXEC;
						end
					end
				end
				B_EXEC: begin
					if (exec_go) begin
						issued_q    <= issued_next;
						state_q     <= B_IDLE;
						if (retire) begin
							head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (is_issue || (count_q == '0))) begin
			out_data_q <= '{accepted: is_issue && room, done_res: 1'b0, done_tag: 8'd0,
				requests_issued: issued_q};
		end else if (exec_go) begin
			out_data_q <= '{accepted: 1'b0, done_res: retire,
				done_tag: retire ? rd_q.tag : 8'd0, requests_issued: issued_next};
		end
	end

endmodule

>>> src/dma_command_queue_timer.sv
// ----------------------------------------------------------------------------
// DMA command queue timer
// Command queue with a fixed-latency timing model for DMA transfers.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   in        request    in_valid / in_ready    in_data  (dmaq_pkg::in_item_t)
//   out       result     out_valid / out_ready  out_data (dmaq_pkg::out_item_t)
//   cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An issue request passes the front end in order: acceptance, 32 steps of the
// serial request-count divider, then the hand-off to the queue. A tick request
// goes from acceptance straight to the hand-off; when the queue holds a command,
// the back end moves from idle to an execute state, where the head entry is read
// and written back, while a tick on an empty queue leaves the back end idle.
// With out_ready low the back end holds its result; once the two-entry operation
// queue is full the front end waits in its hand-off cycle and in_ready stays low.
// Reset clears the queue pointers and counters; queue memory is not cleared.
// ----------------------------------------------------------------------------
module dma_command_queue_timer #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  dmaq_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output dmaq_pkg::out_item_t                   out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dmaq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dmaq_pkg::CFG_DATA_W-1:0]       cfg_data
);

	dmaq_pkg::cfg_t cfg_q;
	logic           op_in_valid;
	logic           op_in_ready;
	dmaq_pkg::op_t  op_in_data;
	logic           op_out_valid;
	logic           op_out_ready;
	dmaq_pkg::op_t  op_out_data;

	assign cfg_ready = 1'b1;

	// Writes to indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count        <= dmaq_pkg::RST_CHANNEL_COUNT;
			cfg_q.block_bytes          <= dmaq_pkg::RST_BLOCK_BYTES;
			cfg_q.load_latency_cycles  <= dmaq_pkg::RST_LOAD_LATENCY;
			cfg_q.store_latency_cycles <= dmaq_pkg::RST_STORE_LATENCY;
			cfg_q.queue_limit          <= dmaq_pkg::RST_QUEUE_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dmaq_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count        <= cfg_data[7:0];
				dmaq_pkg::CFG_BLOCK_BYTES:   cfg_q.block_bytes          <= cfg_data;
				dmaq_pkg::CFG_LOAD_LATENCY:  cfg_q.load_latency_cycles  <= cfg_data;
				dmaq_pkg::CFG_STORE_LATENCY: cfg_q.store_latency_cycles <= cfg_data;
				dmaq_pkg::CFG_QUEUE_LIMIT:   cfg_q.queue_limit          <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	dmaq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.op_valid (op_in_valid),
		.op_ready (op_in_ready),
		.op_data  (op_in_data)
	);

	dmaq_op_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (op_in_valid),
		.push_ready (op_in_ready),
		.push_data  (op_in_data),
		.pop_valid  (op_out_valid),
		.pop_ready  (op_out_ready),
		.pop_data   (op_out_data)
	);

	dmaq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_out_valid),
		.op_ready  (op_out_ready),
		.op_data   (op_out_data),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> src/dmaq_checker.sv
// ----------------------------------------------------------------------------
// DMA command queue timer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "dma_command_queue_timer_assert.svh"

module dmaq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input dmaq_pkg::out_item_t out_data
);

	`DMAQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`DMAQ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled result changed")
	`DMAQ_ASSERT_SAME(a_one_kind, out_valid, !(out_data.accepted && out_data.done_res), "issue and retire in one result")
	`DMAQ_ASSERT_SAME(a_tag_zero, out_valid && !out_data.done_res, out_data.done_tag == 8'd0, "tag reported without a retire")

endmodule

bind dma_command_queue_timer dmaq_checker u_dmaq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DMA command queue timer testbench
// Sends issue and tick requests in random bursts against a randomly stalling
// receiver, predicts every result with a behavioral copy of the queue and
// compares each result in order, field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int QDEPTH      = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PRINT_LIMIT = 50;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	dmaq_pkg::in_item_t              in_data;
	logic                            out_valid;
	logic                            out_ready;
	dmaq_pkg::out_item_t             out_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [dmaq_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dmaq_pkg::CFG_DATA_W-1:0] cfg_data;

	// Mirror of the configuration registers
	logic [7:0]  cfg_channels;
	logic [15:0] cfg_block;
	logic [15:0] cfg_load_lat;
	logic [15:0] cfg_store_lat;
	logic [4:0]  cfg_limit;

	// Mirror of the command queue
	logic [7:0]  q_tag       [QDEPTH];
	logic [31:0] q_reqs_left [QDEPTH];
	logic [15:0] q_wait_left [QDEPTH];
	logic [3:0]  q_head;
	logic [4:0]  q_count;
	logic [31:0] q_issued;

	dmaq_pkg::out_item_t pending_reports[$];
	int        mismatches = 0;
	int        cycles = 0;
	int        burst_left;
	bit        sender_gaps;
	bit        rx_stalls;
	int        hold_cycles_req;

	dma_command_queue_timer #(
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		mismatches++;
	endtask

	// A division by zero gives all ones, as a restoring divider does.
	function automatic logic [31:0] div_all_ones(logic [31:0] num, logic [31:0] den);
		if (den == 32'd0)
			return '1;
		return num / den;
	endfunction

	function automatic dmaq_pkg::out_item_t queue_timer_step(dmaq_pkg::in_item_t item);
		dmaq_pkg::out_item_t res;
		logic [3:0] slot;
		logic [4:0] limit;
		res = '0;
		limit = (cfg_limit > QDEPTH) ? 5'(QDEPTH) : cfg_limit;
		if (item.cmd == dmaq_pkg::CMD_ISSUE) begin
			if (q_count < limit) begin
				slot = q_head + q_count[3:0];
				q_tag[slot] = item.tag;
				q_reqs_left[slot] = div_all_ones(div_all_ones(item.transfer_bytes,
					{24'd0, cfg_channels}), {16'd0, cfg_block});
				q_wait_left[slot] = item.is_store ? cfg_store_lat : cfg_load_lat;
				q_count++;
				res.accepted = 1'b1;
			end
		end else if (q_count != 5'd0) begin
			if (q_reqs_left[q_head] != 32'd0) begin
				q_reqs_left[q_head]--;
				q_issued++;
			end
			// The latency countdown starts on the tick that issues the last request.
			if (q_reqs_left[q_head] == 32'd0) begin
				if (q_wait_left[q_head] != 16'd0)
					q_wait_left[q_head]--;
				if (q_wait_left[q_head] == 16'd0) begin
					res.done_res = 1'b1;
					res.done_tag = q_tag[q_head];
					q_head++;
					q_count--;
				end
			end
		end
		res.requests_issued = q_issued;
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		dmaq_pkg::out_item_t want;
		dmaq_pkg::out_item_t predicted;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					report_mismatch("result with no request waiting", 32'd0, 32'd0);
				end else begin
					want = pending_reports.pop_front();
					if (out_data.accepted !== want.accepted)
						report_mismatch("accepted", out_data.accepted, want.accepted);
					if (out_data.done_res !== want.done_res)
						report_mismatch("done_res", out_data.done_res, want.done_res);
					if (out_data.done_tag !== want.done_tag)
						report_mismatch("done_tag", out_data.done_tag, want.done_tag);
					if (out_data.requests_issued !== want.requests_issued)
						report_mismatch("requests_issued", out_data.requests_issued,
							want.requests_issued);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dmaq_pkg::CFG_CHANNEL_COUNT: cfg_channels = cfg_data[7:0];
					dmaq_pkg::CFG_BLOCK_BYTES:   cfg_block = cfg_data;
					dmaq_pkg::CFG_LOAD_LATENCY:  cfg_load_lat = cfg_data;
					dmaq_pkg::CFG_STORE_LATENCY: cfg_store_lat = cfg_data;
					dmaq_pkg::CFG_QUEUE_LIMIT:   cfg_limit = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predicted = queue_timer_step(in_data);
				pending_reports = {pending_reports, predicted};
			end
		end
	end

	// Receiver: random ready runs and stalls, a steady mode, and long hold-offs on demand.
	initial begin : receiver
		bit rx_state;
		int rx_left;
		rx_state = 1'b0;
		rx_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles_req > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles_req) @(negedge clk);
				hold_cycles_req = 0;
			end else if (!rx_stalls) begin
				out_ready <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_state = !rx_state;
					rx_left = rx_state ? $urandom_range(1, 24) : $urandom_range(1, 6);
				end
				out_ready <= rx_state;
				rx_left--;
			end
		end
	end

	task automatic send_item(dmaq_pkg::in_item_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_gaps ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic [dmaq_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Every request has a result, so an empty expectation queue means the block is idle.
	task automatic configure(logic [7:0] channels, logic [15:0] block, logic [15:0] load_lat,
		logic [15:0] store_lat, logic [4:0] limit);
		drain_results();
		write_register(dmaq_pkg::CFG_CHANNEL_COUNT, {8'd0, channels});
		write_register(dmaq_pkg::CFG_BLOCK_BYTES, block);
		write_register(dmaq_pkg::CFG_LOAD_LATENCY, load_lat);
		write_register(dmaq_pkg::CFG_STORE_LATENCY, store_lat);
		write_register(dmaq_pkg::CFG_QUEUE_LIMIT, {11'd0, limit});
	endtask

	function automatic dmaq_pkg::in_item_t issue_item(logic store, logic [31:0] bytes,
		logic [7:0] tag);
		dmaq_pkg::in_item_t item;
		item.cmd = dmaq_pkg::CMD_ISSUE;
		item.is_store = store;
		item.transfer_bytes = bytes;
		item.tag = tag;
		return item;
	endfunction

	// Tick requests carry random junk in the fields they do not use.
	function automatic dmaq_pkg::in_item_t tick_item();
		dmaq_pkg::in_item_t item;
		item.cmd = dmaq_pkg::CMD_TICK;
		item.is_store = 1'($urandom_range(0, 1));
		item.transfer_bytes = $urandom();
		item.tag = 8'($urandom_range(0, 255));
		return item;
	endfunction

	// A bytes_scale of zero draws transfer sizes from the full 32-bit range.
	task automatic run_random_phase(int count, int issue_pct, int bytes_scale);
		logic [31:0] bytes_max;
		logic [31:0] bytes;
		bytes_max = 32'(cfg_channels) * 32'(cfg_block) * 32'(bytes_scale);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(1, 100) <= issue_pct) begin
				bytes = (bytes_scale == 0) ? $urandom() : $urandom_range(0, bytes_max);
				send_item(issue_item(1'($urandom_range(0, 1)), bytes,
					8'($urandom_range(0, 255))));
			end else begin
				send_item(tick_item());
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_item(tick_item());
		send_item(issue_item(1'b0, 32'd0, 8'h00));
		send_item(tick_item());
		send_item(issue_item(1'b1, 32'd128, 8'hFF));
		send_item(tick_item());
		send_item(tick_item());
		send_item(issue_item(1'b0, 32'd63, 8'h5A));
		send_item(tick_item());
	endtask

	task automatic test_limits_and_latency();
		configure(8'd1, 16'd1, 16'd3, 16'd1, 5'd0);
		send_item(issue_item(1'b0, 32'd7, 8'hA5));
		configure(8'd3, 16'd2, 16'd3, 16'd1, 5'd2);
		send_item(issue_item(1'b0, 32'd12, 8'h3C));
		send_item(issue_item(1'b1, 32'd5, 8'hC3));
		send_item(issue_item(1'b1, 32'd5, 8'h81));
		repeat (7) send_item(tick_item());
	endtask

	task automatic test_random_configs();
		configure(8'($urandom_range(1, 4)), 16'($urandom_range(1, 64)),
			16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)), 5'd31);
		run_random_phase(250, 40, 4);
		rx_stalls = 1'b0;
		configure(8'($urandom_range(1, 8)), 16'($urandom_range(1, 16)),
			16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
			5'($urandom_range(1, 15)));
		run_random_phase(250, 25, 3);
		rx_stalls = 1'b1;
		sender_gaps = 1'b0;
		configure(8'd1, 16'd1, 16'd0, 16'd0, 5'd16);
		run_random_phase(250, 30, 6);
		sender_gaps = 1'b1;
		configure(8'($urandom_range(2, 255)), 16'($urandom_range(1, 255)),
			16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			5'($urandom_range(1, 4)));
		run_random_phase(250, 50, 3);
	endtask

	task automatic test_wide_transfers();
		configure(8'($urandom_range(128, 255)), 16'($urandom_range(32768, 65535)),
			16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)), 5'd16);
		run_random_phase(250, 5, 0);
	endtask

	task automatic test_backpressure();
		configure(8'd1, 16'd4, 16'd1, 16'd2, 5'd16);
		sender_gaps = 1'b0;
		hold_cycles_req = 300;
		run_random_phase(60, 20, 3);
		// The sender stops here until every result is back.
		drain_results();
		sender_gaps = 1'b1;
	endtask

	// These commands never retire within the run, so they come last.
	task automatic test_extreme_settings();
		configure(8'd255, 16'd65535, 16'd65535, 16'd65535, 5'd16);
		send_item(issue_item(1'b1, 32'hFFFF_FFFF, 8'hFF));
		repeat (3) send_item(tick_item());
		configure(8'd0, 16'd1, 16'd0, 16'd65535, 5'd31);
		send_item(issue_item(1'b0, 32'd100, 8'h11));
		configure(8'd1, 16'd0, 16'd0, 16'd0, 5'd31);
		send_item(issue_item(1'b0, 32'hFFFF_FFFF, 8'h22));
		send_item(issue_item(1'b1, 32'd0, 8'h33));
		repeat (3) send_item(tick_item());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_channels = dmaq_pkg::RST_CHANNEL_COUNT;
		cfg_block = dmaq_pkg::RST_BLOCK_BYTES;
		cfg_load_lat = dmaq_pkg::RST_LOAD_LATENCY;
		cfg_store_lat = dmaq_pkg::RST_STORE_LATENCY;
		cfg_limit = dmaq_pkg::RST_QUEUE_LIMIT;
		q_head = '0;
		q_count = '0;
		q_issued = '0;
		burst_left = 0;
		sender_gaps = 1'b1;
		rx_stalls = 1'b1;
		hold_cycles_req = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_limits_and_latency();
		test_random_configs();
		test_wide_transfers();
		test_backpressure();
		test_extreme_settings();

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/dmaq_pkg.sv
src/dmaq_front.sv
src/dmaq_op_fifo.sv
src/dmaq_back.sv
src/dma_command_queue_timer.sv
src/dmaq_checker.sv
dv/tb.sv
